>>> src/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg: shared types and codes of the reversible deque
// Operation codes, result status codes, and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rdq_pkg;

    // Operation codes carried on the mode field.
    localparam logic [2:0] MODE_REVERSE    = 3'd0;
    localparam logic [2:0] MODE_POP_BACK   = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd3;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming beat
        logic exec;      // apply the captured operation to the ring
        logic out_fail;  // load an empty or full status into the result
        logic out_data;  // load the word read from the ring into the result
    } rdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic is_push;
        logic empty;
        logic full;
    } rdq_stat_t;

endpackage

>>> src/rdq_ctrl.sv
// ----------------------------------------------------------------------------
// rdq_ctrl: operation sequencer of the reversible deque
// Steps each accepted beat through capture, execution and, for a pop that
// finds data, a ring read before the result strobe.
// ----------------------------------------------------------------------------
module rdq_ctrl
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  rdq_stat_t stat,
    output rdq_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;
    logic       fail;

    // A pop from an empty queue or a push into a full one reports at once.
    assign fail = (stat.is_pop && stat.empty) || (stat.is_push && stat.full);

    // Next-state and command decode.
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        cmd.out_fail = 1'b0;
        cmd.out_data = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.out_fail = fail;
                done_next    = fail;
                if (stat.is_pop && !stat.empty)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.out_data = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

`ifndef SYNTHESIS
    // A result beat only follows a cycle in which an operation was in flight.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result strobe without an operation in flight");

    // The ring read cycle always ends in a result beat.
    a_read_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> done_reg)
        else $error("ring read did not produce a result");

    // An accepted beat always moves the sequencer into execution.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == S_EXEC)
        else $error("accepted beat did not start execution");
`endif

endmodule

>>> src/rdq_datapath.sv
// ----------------------------------------------------------------------------
// rdq_datapath: ring storage and pointers of the reversible deque
// Holds the captured operation, the ring memory, the head pointer, the
// occupancy count, the reversal flag and the result registers.
// ----------------------------------------------------------------------------
module rdq_datapath
    import rdq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rdq_cmd_t                     cmd,
    input  logic [2:0]                   mode,
    input  logic signed [DATA_WIDTH-1:0] value,
    output rdq_stat_t                    stat,
    output logic [1:0]                   status,
    output logic signed [DATA_WIDTH-1:0] value_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [2:0]            mode_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         occ_reg;
    logic [CW-1:0]         occ_next;
    logic                  rev_reg;
    logic                  rev_next;
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [1:0]            status_reg;
    logic [DATA_WIDTH-1:0] value_res_reg;
    logic [AW-1:0]         pos;
    logic                  at_back;
    logic                  is_pop;
    logic                  is_push;
    logic                  empty;
    logic                  full;
    logic                  mem_we;
    logic                  mem_re;

    // Ring position a given distance past the head, wrapped once.
    function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, off};
        if (sum >= (CW + 1)'(DEPTH))
        begin
            return AW'(sum - (CW + 1)'(DEPTH));
        end
        return AW'(sum);
    endfunction

    // Operation decode; the flag swaps which end is meant.
    always_comb
    begin
        is_pop  = (mode_reg inside {MODE_POP_BACK, MODE_POP_FRONT});
        is_push = (mode_reg inside {MODE_PUSH_BACK, MODE_PUSH_FRONT});
        at_back = (mode_reg inside {MODE_POP_BACK, MODE_PUSH_BACK}) ^ rev_reg;
        empty   = (occ_reg == '0);
        full    = (occ_reg == CW'(DEPTH));
    end

    assign stat.is_pop  = is_pop;
    assign stat.is_push = is_push;
    assign stat.empty   = empty;
    assign stat.full    = full;

    // Pointer, count and flag updates with the ring position touched.
    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        rev_next  = rev_reg;
        pos       = head_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        if (cmd.exec)
        begin
            if (mode_reg == MODE_REVERSE)
            begin
                rev_next = !rev_reg;
            end
            else if (is_pop && !empty)
            begin
                mem_re   = 1'b1;
                occ_next = occ_reg - CW'(1);
                if (at_back)
                begin
                    pos = ring_at(head_reg, occ_reg - CW'(1));
                end
                else
                begin
                    pos       = head_reg;
                    head_next = ring_at(head_reg, CW'(1));
                end
            end
            else if (is_push && !full)
            begin
                mem_we   = 1'b1;
                occ_next = occ_reg + CW'(1);
                if (at_back)
                begin
                    pos = ring_at(head_reg, occ_reg);
                end
                else
                begin
                    head_next = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
                    pos       = head_next;
                end
            end
        end
    end

    // Control state of the ring.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
            rev_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
            rev_reg  <= rev_next;
        end
    end

    // Captured beat and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            word_reg <= value;
        end
        if (cmd.out_fail)
        begin
            status_reg    <= is_pop ? ST_EMPTY : ST_FULL;
            value_res_reg <= '0;
        end
        else if (cmd.out_data)
        begin
            status_reg    <= ST_OK;
            value_res_reg <= rd_data_reg;
        end
    end

    // Ring memory with one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos] <= word_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[pos];
        end
    end

    assign status    = status_reg;
    assign value_res = value_res_reg;

`ifndef SYNTHESIS
    // The count never passes the ring size.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy beyond ring depth");

    // The head pointer stays inside the ring.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(DEPTH - 1))
        else $error("head pointer outside the ring");

    // A refused operation leaves the count and head untouched.
    a_fail_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && ((is_pop && empty) || (is_push && full))
        |=> $stable(occ_reg) && $stable(head_reg))
        else $error("refused operation changed the ring");
`endif

endmodule

>>> src/reversible_deque_unit.sv
// ----------------------------------------------------------------------------
// reversible_deque_unit: double-ended queue with a reversal flag
// A ring of DEPTH words of DATA_WIDTH bits that takes push, pop and reverse
// operations at either end, with front and back swapped while reversed.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat (mode, value) is taken at a rising edge with start high
//   and busy low. busy stays high while the operation is in progress.
//   A result beat appears for one cycle with done high on status and
//   value_res; the receiver has no way to stall it and must take it then.
//   Reverse and successful pushes give no result beat.
// Timing:
//   Reverse and pushes pass through capture and execute; a refused pop or
//   push gives done on the cycle after execution. A pop that finds data
//   adds the registered read of the single-port ring memory, and done
//   follows on the next cycle. The next beat may be taken while the result
//   of the previous one is on the ports.
// Reset:
//   rst_n clears the head pointer, the word count and the reversal flag;
//   the ring memory is not cleared, as no pop reads an unwritten word.
// ----------------------------------------------------------------------------
module reversible_deque_unit
    import rdq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   mode,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [DATA_WIDTH-1:0] value_res
);

    rdq_cmd_t  cmd;
    rdq_stat_t stat;

    // Operation sequencer.
    rdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Ring storage, pointers and result registers.
    rdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mode      (mode),
        .value     (value),
        .stat      (stat),
        .status    (status),
        .value_res (value_res)
    );

endmodule
